### rtl/stvp_pkg.sv
package stvp_pkg;

  // Field widths
  localparam int unsigned StickW = 16;
  localparam int unsigned PullW  = 12;
  localparam int unsigned HeadW  = 15;
  localparam int unsigned MagW   = 14;
  localparam int unsigned GenW   = 32;
  localparam int unsigned CntW   = 7;
  localparam int unsigned LvlW   = 15;
  localparam int unsigned FolW   = 14;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  // Follow watchdog and backoff
  localparam logic [CntW-1:0] WatchdogSamples = 7'd60;
  localparam logic [CntW-1:0] BackoffPolls    = 7'd120;
  localparam logic [15:0]     ProgressMargin  = 16'd128;

  // Button masks
  localparam logic [15:0] BtnWalkFwd   = 16'h0800;
  localparam logic [15:0] BtnWalkBack  = 16'h0400;
  localparam logic [15:0] BtnTurnLeft  = 16'h0200;
  localparam logic [15:0] BtnTurnRight = 16'h0100;
  localparam logic [15:0] BtnStrafeL   = 16'h0020;
  localparam logic [15:0] BtnStrafeR   = 16'h0010;
  localparam logic [15:0] BtnLTrig     = 16'h2000;
  localparam logic [15:0] BtnRTrig     = 16'h4000;
  localparam logic [15:0] BtnLPrim     = 16'h0002;
  localparam logic [15:0] BtnLSec      = 16'h0008;
  localparam logic [15:0] BtnLMenu     = 16'h1000;
  localparam logic [15:0] BtnRClick    = 16'h0001;
  localparam logic [15:0] BtnRPrim     = 16'h8000;
  localparam logic [15:0] BtnRSec      = 16'h0004;
  localparam logic [15:0] MovingMask   = 16'h2F30;

  localparam logic signed [16:0] SatPos = 17'sd16384;
  localparam logic signed [16:0] SatNeg = -17'sd16384;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgFollowEnabled = 3'd0,
    CfgFollowEngage  = 3'd1,
    CfgFollowRelease = 3'd2,
    CfgInjectNeg     = 3'd3,
    CfgAxisEngage    = 3'd4,
    CfgAxisRelease   = 3'd5,
    CfgTriggerLevel  = 3'd6,
    CfgSqueezeLevel  = 3'd7
  } cfg_idx_e;

  // Follow settings
  typedef struct packed {
    logic [FolW-1:0] engage;
    logic [FolW-1:0] release_lvl;
    logic            inject_neg;
  } follow_cfg_t;

  // One poll seen by the follow machine
  typedef struct packed {
    logic                    step;
    logic                    head_ok;
    logic                    moving;
    logic signed [HeadW-1:0] head;
    logic [GenW-1:0]         gen;
  } follow_req_t;

  typedef struct packed {
    logic turn_right;
    logic turn_left;
    logic injecting;
  } follow_rsp_t;

endpackage

### rtl/stvp_axis_latch.sv
module stvp_axis_latch (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic signed [stvp_pkg::StickW-1:0] value_i,
  input  logic [stvp_pkg::LvlW-1:0]          engage_i,
  input  logic [stvp_pkg::LvlW-1:0]          release_i,
  output logic                               pos_o,
  output logic                               neg_o
);
  import stvp_pkg::*;

  logic pos_q, neg_q, pos_d, neg_d;
  logic signed [16:0] v, eng, rel;

  assign v   = 17'(value_i);
  assign eng = $signed({2'b00, engage_i});
  assign rel = $signed({2'b00, release_i});

  // Release a set latch, then engage if both are clear
  always_comb begin
    pos_d = pos_q && !(v < rel);
    neg_d = neg_q && !(v > -rel);
    if (!pos_d && !neg_d) begin
      if (v > eng) begin
        pos_d = 1'b1;
      end else if (v < -eng) begin
        neg_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 1'b0;
      neg_q <= 1'b0;
    end else if (step_i) begin
      pos_q <= pos_d;
      neg_q <= neg_d;
    end
  end

  assign pos_o = pos_d;
  assign neg_o = neg_d;

endmodule

### rtl/stvp_follow.sv
module stvp_follow (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stvp_pkg::follow_cfg_t cfg_i,
  input  stvp_pkg::follow_req_t req_i,
  output stvp_pkg::follow_rsp_t rsp_o
);
  import stvp_pkg::*;

  logic            on_q, on_d;
  logic [CntW-1:0] fresh_q, fresh_d;
  logic [CntW-1:0] backoff_q, backoff_d;
  logic [MagW-1:0] start_q, start_d;
  logic [GenW-1:0] gen_q;

  logic                fresh, stop, right;
  logic [HeadW-1:0]    mag;
  logic [MagW-1:0]     mag_sat;
  logic [CntW:0]       cnt;
  logic signed [15:0]  thr;

  assign fresh   = req_i.gen != gen_q;
  assign stop    = !req_i.head_ok || req_i.moving || (backoff_q != '0);
  assign mag     = req_i.head[HeadW-1] ? HeadW'(-req_i.head) : req_i.head;
  assign mag_sat = mag[HeadW-1] ? {MagW{1'b1}} : mag[MagW-1:0];
  assign right   = cfg_i.inject_neg ? req_i.head[HeadW-1] : (req_i.head > 0);

  // Follow decision for one poll
  always_comb begin
    on_d      = on_q;
    fresh_d   = fresh_q;
    backoff_d = backoff_q;
    start_d   = start_q;
    cnt       = '0;
    thr       = '0;
    rsp_o     = '0;
    if (stop) begin
      on_d    = 1'b0;
      fresh_d = '0;
      if (backoff_q != '0) begin
        backoff_d = backoff_q - CntW'(1);
      end
    end else begin
      if (!on_q && (mag > {1'b0, cfg_i.engage})) begin
        on_d    = 1'b1;
        fresh_d = '0;
        start_d = mag_sat;
      end else if (on_q && (mag < {1'b0, cfg_i.release_lvl})) begin
        on_d = 1'b0;
      end
      if (on_d) begin
        cnt              = {1'b0, fresh_d} + {{CntW{1'b0}}, fresh};
        rsp_o.turn_right = right;
        rsp_o.turn_left  = !right;
        rsp_o.injecting  = 1'b1;
        thr              = $signed({2'b00, start_d} - ProgressMargin);
        // Watchdog: no progress since the last trip stops follow
        if (cnt > {1'b0, WatchdogSamples}) begin
          if ($signed({1'b0, mag}) > thr) begin
            on_d            = 1'b0;
            rsp_o.injecting = 1'b0;
            backoff_d       = BackoffPolls;
          end
          cnt     = '0;
          start_d = mag_sat;
        end
        fresh_d = cnt[CntW-1:0];
      end
    end
    if (!req_i.step) begin
      rsp_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q      <= 1'b0;
      fresh_q   <= '0;
      backoff_q <= '0;
      start_q   <= '0;
      gen_q     <= '0;
    end else if (req_i.step) begin
      on_q      <= on_d;
      fresh_q   <= fresh_d;
      backoff_q <= backoff_d;
      start_q   <= start_d;
      gen_q     <= req_i.gen;
    end
  end

endmodule

### rtl/vr_stick_to_pad_mapper.sv
// Pipeline: an accepted input beat passes through the input register, then the result
// register, from which the result beat is offered on m_axis.
// Throughput: one poll per cycle; a held result stalls the input stage once both
// registers are full.
// Reset (rst_ni low, asynchronous): pipeline empty, latches and follow state clear,
// configuration registers at their default levels.
module vr_stick_to_pad_mapper (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [stvp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [stvp_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pad_buttons[15:0], pad_x[31:16], pad_y[47:32], hand_buttons[55:48],
  // left_stick_x[71:56], left_stick_y[87:72], right_stick_x[103:88],
  // pulls[151:104], head_offset[166:152], head_generation[198:167],
  // misc_flags[200:199], zero fill[207:201]
  input  logic [207:0]                       s_axis_tdata,
  // port_index[1:0]
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_buttons[15:0], out_x[31:16], out_y[47:32], turn_inject[48],
  // zero fill[55:49]
  output logic [55:0]                        m_axis_tdata
);
  import stvp_pkg::*;

  // Configuration registers
  logic            follow_en_q;
  logic [FolW-1:0] follow_eng_q, follow_rel_q;
  logic            inject_neg_q;
  logic [LvlW-1:0] axis_eng_q, axis_rel_q;
  logic [PullW-1:0] trig_lvl_q, sqz_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_en_q  <= 1'b0;
      follow_eng_q <= 14'd960;
      follow_rel_q <= 14'd192;
      inject_neg_q <= 1'b0;
      axis_eng_q   <= 15'd6554;
      axis_rel_q   <= 15'd4588;
      trig_lvl_q   <= 12'd2457;
      sqz_lvl_q    <= 12'd2867;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgFollowEnabled: follow_en_q  <= cfg_data_i[0];
        CfgFollowEngage:  follow_eng_q <= cfg_data_i[FolW-1:0];
        CfgFollowRelease: follow_rel_q <= cfg_data_i[FolW-1:0];
        CfgInjectNeg:     inject_neg_q <= cfg_data_i[0];
        CfgAxisEngage:    axis_eng_q   <= cfg_data_i[LvlW-1:0];
        CfgAxisRelease:   axis_rel_q   <= cfg_data_i[LvlW-1:0];
        CfgTriggerLevel:  trig_lvl_q   <= cfg_data_i[PullW-1:0];
        CfgSqueezeLevel:  sqz_lvl_q    <= cfg_data_i[PullW-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage
  logic         in_valid_q, out_valid_q;
  logic [200:0] in_data_q;
  logic [1:0]   in_port_q;
  logic         advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata[200:0];
      in_port_q <= s_axis_tuser;
    end
  end

  // Unpack fields
  logic [15:0]               base;
  logic signed [StickW-1:0]  px, py, lx, ly, rx;
  logic [7:0]                hb;
  logic [47:0]               pulls;
  logic signed [HeadW-1:0]   head;
  logic [GenW-1:0]           gen;
  logic [1:0]                misc;
  logic                      active;

  assign base  = in_data_q[15:0];
  assign px    = in_data_q[31:16];
  assign py    = in_data_q[47:32];
  assign hb    = in_data_q[55:48];
  assign lx    = in_data_q[71:56];
  assign ly    = in_data_q[87:72];
  assign rx    = in_data_q[103:88];
  assign pulls = in_data_q[151:104];
  assign head  = in_data_q[166:152];
  assign gen   = in_data_q[198:167];
  assign misc  = in_data_q[200:199];

  assign active = (in_port_q == 2'd0) && !misc[0] && (hb[1:0] != 2'b00);

  // Stick latches
  logic step;
  logic walk_fwd, walk_back, strafe_r, strafe_l, turn_r, turn_l;

  assign step = advance && active;

  stvp_axis_latch u_walk (
    .clk_i, .rst_ni, .step_i(step), .value_i(ly),
    .engage_i(axis_eng_q), .release_i(axis_rel_q),
    .pos_o(walk_fwd), .neg_o(walk_back)
  );

  stvp_axis_latch u_strafe (
    .clk_i, .rst_ni, .step_i(step), .value_i(lx),
    .engage_i(axis_eng_q), .release_i(axis_rel_q),
    .pos_o(strafe_r), .neg_o(strafe_l)
  );

  stvp_axis_latch u_turn (
    .clk_i, .rst_ni, .step_i(step), .value_i(rx),
    .engage_i(axis_eng_q), .release_i(axis_rel_q),
    .pos_o(turn_r), .neg_o(turn_l)
  );

  // Synthesized buttons from latches, pulls and hand buttons
  logic [15:0] vb;

  always_comb begin
    vb = '0;
    if (walk_fwd)  vb |= BtnWalkFwd;
    if (walk_back) vb |= BtnWalkBack;
    if (strafe_r)  vb |= BtnStrafeR;
    if (strafe_l)  vb |= BtnStrafeL;
    if (turn_r)    vb |= BtnTurnRight;
    if (turn_l)    vb |= BtnTurnLeft;
    if (pulls[11:0]  > trig_lvl_q) vb |= BtnLTrig;
    if (pulls[23:12] > sqz_lvl_q)  vb |= BtnStrafeL;
    if (pulls[35:24] > sqz_lvl_q)  vb |= BtnStrafeR;
    if (pulls[47:36] > trig_lvl_q) vb |= BtnRTrig;
    if (hb[2]) vb |= BtnLPrim;
    if (hb[3]) vb |= BtnLSec;
    if (hb[4]) vb |= BtnLMenu;
    if (hb[5]) vb |= BtnRClick;
    if (hb[6]) vb |= BtnRPrim;
    if (hb[7]) vb |= BtnRSec;
  end

  // Gaze follow
  follow_cfg_t fcfg;
  follow_req_t freq;
  follow_rsp_t frsp;

  assign fcfg.engage      = follow_eng_q;
  assign fcfg.release_lvl = follow_rel_q;
  assign fcfg.inject_neg  = inject_neg_q;

  assign freq.step    = step && follow_en_q;
  assign freq.head_ok = misc[1];
  assign freq.moving  = ((base | vb) & MovingMask) != '0;
  assign freq.head    = head;
  assign freq.gen     = gen;

  stvp_follow u_follow (
    .clk_i, .rst_ni, .cfg_i(fcfg), .req_i(freq), .rsp_o(frsp)
  );

  // Sum and saturate the analog axes
  logic signed [16:0] sum_x, sum_y;
  logic signed [15:0] sat_x, sat_y;
  logic [15:0]        res_btn;

  assign sum_x = 17'(px) + 17'(rx);
  assign sum_y = 17'(py) + 17'(ly);

  always_comb begin
    if (sum_x > SatPos)      sat_x = 16'(SatPos);
    else if (sum_x < SatNeg) sat_x = 16'(SatNeg);
    else                     sat_x = sum_x[15:0];
    if (sum_y > SatPos)      sat_y = 16'(SatPos);
    else if (sum_y < SatNeg) sat_y = 16'(SatNeg);
    else                     sat_y = sum_y[15:0];
    res_btn = base | vb;
    if (frsp.turn_right) res_btn |= BtnTurnRight;
    if (frsp.turn_left)  res_btn |= BtnTurnLeft;
  end

  // Result register
  logic [48:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (active) begin
        out_data_q <= {frsp.injecting, sat_y, sat_x, res_btn};
      end else begin
        out_data_q <= {1'b0, py, px, base};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_data_q};

endmodule

### dv/vr_stick_to_pad_mapper_test.sv
`timescale 1ns / 1ps

module vr_stick_to_pad_mapper_test;
  import stvp_pkg::*;

  localparam int StallLimit = 2000;
  localparam int LongHold   = 200;

  // One poll, packed as on s_axis_tdata with the port on top
  typedef struct packed {
    logic [1:0]         port;
    logic [1:0]         misc;
    logic [31:0]        gen;
    logic signed [14:0] head;
    logic [47:0]        pulls;
    logic signed [15:0] right_x;
    logic signed [15:0] left_y;
    logic signed [15:0] left_x;
    logic [7:0]         hand;
    logic signed [15:0] pad_y;
    logic signed [15:0] pad_x;
    logic [15:0]        pad_buttons;
  } pad_poll_t;

  // One result, packed as on m_axis_tdata[48:0]
  typedef struct packed {
    logic               injecting;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic [15:0]        buttons;
  } pad_result_t;

  class pad_map_scoreboard;
    logic        follow_en;
    logic [13:0] follow_engage_lvl;
    logic [13:0] follow_release_lvl;
    logic        inject_neg;
    logic [14:0] axis_engage_lvl;
    logic [14:0] axis_release_lvl;
    logic [11:0] trigger_lvl;
    logic [11:0] squeeze_lvl;
    logic [5:0]  move_latches;
    logic        follow_on;
    logic [6:0]  fresh_cnt;
    logic [6:0]  backoff_cnt;
    logic [13:0] start_mag;
    logic [31:0] last_gen;
    pad_result_t expected_pads[$];
    int          errors;

    function new();
      follow_en = 1'b0;
      follow_engage_lvl = 14'd960;
      follow_release_lvl = 14'd192;
      inject_neg = 1'b0;
      axis_engage_lvl = 15'd6554;
      axis_release_lvl = 15'd4588;
      trigger_lvl = 12'd2457;
      squeeze_lvl = 12'd2867;
      move_latches = '0;
      follow_on = 1'b0;
      fresh_cnt = '0;
      backoff_cnt = '0;
      start_mag = '0;
      last_gen = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [14:0] value);
      case (idx)
        CfgFollowEnabled: follow_en = value[0];
        CfgFollowEngage:  follow_engage_lvl = value[13:0];
        CfgFollowRelease: follow_release_lvl = value[13:0];
        CfgInjectNeg:     inject_neg = value[0];
        CfgAxisEngage:    axis_engage_lvl = value;
        CfgAxisRelease:   axis_release_lvl = value;
        CfgTriggerLevel:  trigger_lvl = value[11:0];
        CfgSqueezeLevel:  squeeze_lvl = value[11:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] clip_unit(int v);
      if (v > 16384) return 16'sd16384;
      if (v < -16384) return -16'sd16384;
      return 16'(v);
    endfunction

    function logic [13:0] clamp_mag(int m);
      return (m > 16383) ? 14'h3FFF : 14'(m);
    endfunction

    // Release a set direction first, then let the axis engage one side
    function void step_latch(int v, int pos_bit, int neg_bit);
      int   eng;
      int   rel;
      logic p;
      logic n;
      eng = int'(axis_engage_lvl);
      rel = int'(axis_release_lvl);
      p = move_latches[pos_bit];
      n = move_latches[neg_bit];
      if (p && v < rel) p = 1'b0;
      if (n && v > -rel) n = 1'b0;
      if (!p && !n) begin
        if (v > eng) p = 1'b1;
        else if (v < -eng) n = 1'b1;
      end
      move_latches[pos_bit] = p;
      move_latches[neg_bit] = n;
    endfunction

    function pad_result_t map_poll(pad_poll_t p);
      pad_result_t r;
      logic [15:0] vb;
      logic        fresh;
      logic        moving;
      logic        go_right;
      int          head;
      int          mag;
      int          cnt;
      vb = '0;
      r.buttons = p.pad_buttons;
      r.x = p.pad_x;
      r.y = p.pad_y;
      r.injecting = 1'b0;
      // Other ports, disabled input and idle hands pass through untouched
      if (p.port != 2'd0 || p.misc[0] || p.hand[1:0] == 2'b00) return r;

      step_latch(int'(p.left_y), 0, 1);
      step_latch(int'(p.left_x), 2, 3);
      step_latch(int'(p.right_x), 4, 5);
      if (move_latches[0]) vb |= BtnWalkFwd;
      if (move_latches[1]) vb |= BtnWalkBack;
      if (move_latches[2]) vb |= BtnStrafeR;
      if (move_latches[3]) vb |= BtnStrafeL;
      if (move_latches[4]) vb |= BtnTurnRight;
      if (move_latches[5]) vb |= BtnTurnLeft;

      if (p.pulls[11:0] > trigger_lvl) vb |= BtnLTrig;
      if (p.pulls[23:12] > squeeze_lvl) vb |= BtnStrafeL;
      if (p.pulls[35:24] > squeeze_lvl) vb |= BtnStrafeR;
      if (p.pulls[47:36] > trigger_lvl) vb |= BtnRTrig;
      if (p.hand[2]) vb |= BtnLPrim;
      if (p.hand[3]) vb |= BtnLSec;
      if (p.hand[4]) vb |= BtnLMenu;
      if (p.hand[5]) vb |= BtnRClick;
      if (p.hand[6]) vb |= BtnRPrim;
      if (p.hand[7]) vb |= BtnRSec;

      // Gaze follow: runs only while the user stands still
      if (follow_en) begin
        fresh = (p.gen != last_gen);
        moving = ((p.pad_buttons | vb) & MovingMask) != 16'd0;
        last_gen = p.gen;
        if (!p.misc[1] || moving || backoff_cnt != 7'd0) begin
          follow_on = 1'b0;
          fresh_cnt = '0;
          if (backoff_cnt != 7'd0) backoff_cnt = backoff_cnt - 7'd1;
        end else begin
          head = int'(p.head);
          mag = (head < 0) ? -head : head;
          if (!follow_on && mag > int'(follow_engage_lvl)) begin
            follow_on = 1'b1;
            fresh_cnt = '0;
            start_mag = clamp_mag(mag);
          end else if (follow_on && mag < int'(follow_release_lvl)) begin
            follow_on = 1'b0;
          end
          if (follow_on) begin
            go_right = inject_neg ? (head < 0) : (head > 0);
            cnt = int'(fresh_cnt) + int'(fresh);
            vb |= go_right ? BtnTurnRight : BtnTurnLeft;
            r.injecting = 1'b1;
            // No-progress watchdog, counted in fresh head samples
            if (cnt > int'(WatchdogSamples)) begin
              if (mag > int'(start_mag) - int'(ProgressMargin)) begin
                follow_on = 1'b0;
                r.injecting = 1'b0;
                backoff_cnt = BackoffPolls;
              end
              cnt = 0;
              start_mag = clamp_mag(mag);
            end
            fresh_cnt = 7'(cnt);
          end
        end
      end

      r.buttons = p.pad_buttons | vb;
      r.x = clip_unit(int'(p.pad_x) + int'(p.right_x));
      r.y = clip_unit(int'(p.pad_y) + int'(p.left_y));
      return r;
    endfunction

    function void note_poll(pad_poll_t p);
      expected_pads.push_back(map_poll(p));
    endfunction

    function void check_result(pad_result_t got);
      pad_result_t want;
      if (expected_pads.size() == 0) begin
        $display("%0t: unexpected result beat, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_pads.pop_front();
      if (got.buttons !== want.buttons) begin
        $display("%0t: out_buttons mismatch, expected %h, got %h", $time, want.buttons,
                 got.buttons);
        errors++;
      end
      if (got.x !== want.x) begin
        $display("%0t: out_x mismatch, expected %0d, got %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: out_y mismatch, expected %0d, got %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.injecting !== want.injecting) begin
        $display("%0t: turn_inject mismatch, expected %b, got %b", $time,
                 want.injecting, got.injecting);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [207:0]        s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [55:0]         m_axis_tdata;

  pad_map_scoreboard sb = new();
  int          polls_sent = 0;
  int          tx_calm = 0;
  int          rx_calm = 0;
  bit          rx_hold_req = 1'b0;
  int          idle_cycles = 0;
  logic [31:0] head_gen = '0;

  vr_stick_to_pad_mapper DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Draw a random wait, with occasional stretches of back-to-back beats
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  // Offer one poll and hold it until the block takes it
  task automatic send_poll(pad_poll_t p);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, p[200:0]};
    s_axis_tuser <= p.port;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_poll(p);
    polls_sent++;
  endtask

  // Stop offering and let every pending result come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_pads.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataW'(value);
    sb.write_reg(idx, CfgDataW'(value));
    @(posedge clk_i);
  endtask

  // Reprogram all levels once the pipeline is empty
  task automatic program_levels(bit fe, int f_eng, int f_rel, bit inv, int a_eng, int a_rel,
                                int trig, int sqz);
    drain();
    repeat (4) @(posedge clk_i);
    write_reg(CfgFollowEnabled, fe);
    write_reg(CfgFollowEngage, f_eng);
    write_reg(CfgFollowRelease, f_rel);
    write_reg(CfgInjectNeg, inv);
    write_reg(CfgAxisEngage, a_eng);
    write_reg(CfgAxisRelease, a_rel);
    write_reg(CfgTriggerLevel, trig);
    write_reg(CfgSqueezeLevel, sqz);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [11:0] pull_value(int lvl);
    int v;
    case ($urandom_range(0, 3))
      0: v = lvl + int'($urandom_range(0, 2)) - 1;
      1: v = $urandom_range(0, 1) ? 0 : 4095;
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  function automatic logic [15:0] stick_value();
    int v;
    int sgn;
    sgn = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 5))
      0, 1: v = int'($urandom_range(0, 32768)) - 16384;
      2: v = sgn * (int'(sb.axis_engage_lvl) + int'($urandom_range(0, 2)) - 1);
      3: v = sgn * (int'(sb.axis_release_lvl) + int'($urandom_range(0, 2)) - 1);
      4: v = 0;
      default: v = $urandom;
    endcase
    return 16'(v);
  endfunction

  function automatic logic [15:0] in_range_value();
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  // A still user on port 0: no moving buttons, small sticks, light pulls
  function automatic pad_poll_t quiet_poll();
    pad_poll_t p;
    int        span;
    span = int'(sb.axis_release_lvl) - 1;
    if (span > 2000) span = 2000;
    p = '0;
    p.misc = 2'b10;
    p.hand = {6'($urandom), 2'($urandom_range(1, 3))};
    p.pad_buttons = 16'($urandom) & ~MovingMask;
    p.pad_x = in_range_value();
    p.pad_y = in_range_value();
    if (span > 0 && $urandom_range(0, 1)) begin
      p.left_x = 16'(int'($urandom_range(0, 2 * span)) - span);
      p.left_y = 16'(int'($urandom_range(0, 2 * span)) - span);
      p.right_x = 16'(int'($urandom_range(0, 2 * span)) - span);
    end
    p.pulls = {12'($urandom_range(0, sb.trigger_lvl)), 12'($urandom_range(0, sb.squeeze_lvl)),
               12'($urandom_range(0, sb.squeeze_lvl)), 12'($urandom_range(0, sb.trigger_lvl))};
    p.gen = head_gen;
    return p;
  endfunction

  function automatic pad_poll_t stick_poll();
    pad_poll_t p;
    p.port = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
    p.misc = {1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 7) == 0)};
    p.hand = {6'($urandom), 2'($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 3))};
    p.pad_buttons = 16'($urandom);
    p.pad_x = in_range_value();
    p.pad_y = in_range_value();
    p.left_x = stick_value();
    p.left_y = stick_value();
    p.right_x = stick_value();
    p.pulls = {pull_value(sb.trigger_lvl), pull_value(sb.squeeze_lvl),
               pull_value(sb.squeeze_lvl), pull_value(sb.trigger_lvl)};
    p.head = 15'($urandom);
    if ($urandom_range(0, 1)) head_gen = head_gen + 32'd1;
    p.gen = head_gen;
    return p;
  endfunction

  function automatic pad_poll_t noise_poll();
    pad_poll_t    p;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p = raw[$bits(pad_poll_t)-1:0];
    if ($urandom_range(0, 1)) p.port = 2'd0;
    return p;
  endfunction

  // Hold a head offset while the user stays still, so follow engages,
  // trips its watchdog and backs off; drift down now and then for progress
  task automatic follow_run(int len);
    pad_poll_t p;
    int        mag;
    int        sgn;
    int        drift;
    int        hv;
    if ($urandom_range(0, 3) == 0) mag = $urandom_range(0, 16384);
    else mag = int'(sb.follow_engage_lvl) + int'($urandom_range(1, 1500));
    sgn = $urandom_range(0, 1) ? 1 : -1;
    drift = $urandom_range(0, 1) ? int'($urandom_range(1, 4)) : 0;
    for (int i = 0; i < len; i++) begin
      p = quiet_poll();
      if ($urandom_range(0, 3) != 0) begin
        head_gen = head_gen + 32'd1;
        mag = (mag > drift) ? mag - drift : 0;
      end
      p.gen = head_gen;
      hv = sgn * mag;
      if (hv > 16383) hv = 16383;
      if (hv < -16384) hv = -16384;
      p.head = 15'(hv);
      case ($urandom_range(0, 49))
        0: p.misc[1] = 1'b0;
        1: p.pad_buttons |= MovingMask & (16'd1 << $urandom_range(4, 13));
        2: p.head = '0;
        3: p.left_y = 16'sd16384;
        default: ;
      endcase
      send_poll(p);
    end
  endtask

  task automatic run_phase(int count, bit hold_mid, bit pause_mid);
    int start;
    bit mid_done;
    start = polls_sent;
    mid_done = 1'b0;
    while (polls_sent - start < count) begin
      if (!mid_done && polls_sent - start >= count / 2) begin
        if (hold_mid) rx_hold_req = 1'b1;
        if (pause_mid) drain();
        mid_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: follow_run($urandom_range(0, 2) == 0 ? $urandom_range(150, 260)
                                                       : $urandom_range(10, 80));
        3, 4, 5, 6: send_poll(stick_poll());
        default: send_poll(noise_poll());
      endcase
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = LongHold;
      end else begin
        stall = draw_wait(rx_calm);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata[48:0]);
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    pad_poll_t p;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pass-through cases: other port, disabled input, no hand active
    p = noise_poll();
    p.port = 2'd1;
    p.pad_x = 16'h8000;
    p.pad_y = 16'h7FFF;
    send_poll(p);
    p = quiet_poll();
    p.hand[1:0] = 2'b11;
    p.misc = 2'b11;
    send_poll(p);
    p = quiet_poll();
    p.hand = 8'hFC;
    send_poll(p);

    // Full deflection both ways, then release; saturate x and y
    p = quiet_poll();
    p.hand = 8'hFF;
    p.pad_buttons = '0;
    p.left_x = 16'sd16384;
    p.left_y = 16'sd16384;
    p.right_x = 16'sd16384;
    p.pad_x = 16'sd16384;
    p.pad_y = 16'sd16384;
    p.pulls = '1;
    send_poll(p);
    p.left_x = -16'sd16384;
    p.left_y = -16'sd16384;
    p.right_x = -16'sd16384;
    p.pad_x = -16'sd16384;
    p.pad_y = -16'sd16384;
    p.pulls = '0;
    send_poll(p);
    p = quiet_poll();
    p.hand = 8'h02;
    send_poll(p);
    p.pad_x = 16'h7FFF;
    p.right_x = 16'h7FFF;
    p.pad_y = 16'h8000;
    p.left_y = 16'h8000;
    p.pulls = {12'd2458, 12'd2867, 12'd2868, 12'd2457};
    send_poll(p);

    // Follow machine: engage, hold, release, invalid head, movement
    program_levels(1'b1, 960, 192, 1'b0, 6554, 4588, 2457, 2867);
    p = quiet_poll();
    p.gen = 32'd1;
    p.head = 15'h4000;
    send_poll(p);
    send_poll(p);
    p.gen = 32'd2;
    p.head = '0;
    send_poll(p);
    p.head = 15'sd11520;
    send_poll(p);
    p.misc[1] = 1'b0;
    send_poll(p);
    p.misc[1] = 1'b1;
    send_poll(p);
    p.pad_buttons = BtnStrafeR;
    send_poll(p);
    p.pad_buttons = '0;
    p.gen = 32'hFFFF_FFFF;
    send_poll(p);
    p.pulls[47:36] = 12'hFFF;
    p.head = 15'h3FFF;
    send_poll(p);
    p = noise_poll();
    p.port = 2'd0;
    send_poll(p);

    // Random phases across default, extreme and random levels
    head_gen = $urandom;
    run_phase(330, 1'b0, 1'b1);
    program_levels(1'b1, 11520, 11520, 1'b1, 16384, 16384, 4095, 4095);
    run_phase(300, 1'b0, 1'b0);
    program_levels(1'b1, 0, 0, 1'b0, 0, 0, 0, 0);
    run_phase(300, 1'b0, 1'b0);
    program_levels(1'b1, $urandom_range(500, 4000), $urandom_range(0, 500), 1'b0,
                   $urandom_range(2000, 16384), $urandom_range(0, 2000),
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
    run_phase(330, 1'b1, 1'b0);
    program_levels(1'b0, $urandom_range(0, 11520), $urandom_range(0, 11520), 1'b1,
                   $urandom_range(0, 16384), $urandom_range(0, 16384),
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
    run_phase(300, 1'b0, 1'b0);
    program_levels(1'b1, $urandom_range(0, 11520), $urandom_range(0, 11520), 1'b1,
                   $urandom_range(0, 16384), $urandom_range(0, 16384),
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
    run_phase(330, 1'b0, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/stvp_pkg.sv
rtl/stvp_axis_latch.sv
rtl/stvp_follow.sv
rtl/vr_stick_to_pad_mapper.sv
dv/vr_stick_to_pad_mapper_test.sv
